// ===== rtl/mmh_pkg.sv =====
// shared types, constants and helpers for the min-max heap insert block
// no dependencies; imported by mmh_ram and min_max_heap_insert
package mmh_pkg;

  localparam int CAPACITY_DEF = 1024;
  localparam int KEY_BITS_DEF = 16;

  localparam int IN_KEY_W   = 16;
  localparam int ID_OUT_W   = 11;
  localparam int KEY_OUT_W  = 16;
  localparam int OUT_DATA_W = 96;
  localparam int OUT_PAD_W  = OUT_DATA_W - (4 * ID_OUT_W + 3 * KEY_OUT_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PCMP,
    ST_GCMP,
    ST_WITEM,
    ST_RROOT,
    ST_RLAST,
    ST_RBOT,
    ST_DONE
  } state_t;

  // index of the highest set bit, zero for zero
  function automatic logic [4:0] msb_index(input logic [31:0] v);
    logic [4:0] r;
    r = '0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) r = 5'(i);
    end
    return r;
  endfunction

endpackage

// ===== rtl/mmh_ram.sv =====
// heap entry store: one write port, one read port, registered read data
// depends on mmh_pkg
module mmh_ram #(
  parameter int DEPTH = mmh_pkg::CAPACITY_DEF,
  parameter int DW    = mmh_pkg::KEY_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);
  import mmh_pkg::*;

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

// ===== rtl/min_max_heap_insert.sv =====
// min-max heap insert, top level: sequencer, bubble-up and report readout
// depends on mmh_pkg and mmh_ram
//
// Each input beat inserts one key, tagged with an arrival id, into a min-max heap kept in a
// single-port-read RAM, and produces one output beat with the count, the root, the last slot
// and the leftmost slot of the bottom level. One item is handled at a time, and its pace
// is set by the RAM read port: every level of the bubble-up needs one registered read, and
// the report needs three more reads. A new input beat is taken while the previous result
// still waits.
module min_max_heap_insert #(
  parameter int CAPACITY = mmh_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = mmh_pkg::KEY_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [mmh_pkg::IN_KEY_W-1:0]    s_axis_tdata,   // key
  input  logic [0:0]                      s_axis_tuser,   // first
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [mmh_pkg::OUT_DATA_W-1:0]  m_axis_tdata,   // count, root_id, root_key, last_id,
                                                          // last_key, bottom_first_id,
                                                          // bottom_first_key, zero pad
  output logic [0:0]                      m_axis_tuser    // dropped
);
  import mmh_pkg::*;

  localparam int SW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int EW = KEY_BITS + SW;

  state_t state, state_next;

  logic [SW-1:0]       cnt, nid, pos, pos_next, bot;
  logic [KEY_BITS-1:0] item_key;
  logic [SW-1:0]       item_id;
  logic                want_min, want_next, lvl_min, drop;
  logic [KEY_BITS-1:0] root_key, last_key;
  logic [SW-1:0]       root_id, last_id;

  logic                accept, in_first, full, swap, move;
  logic [SW-1:0]       base_cnt, base_id, new_cnt, rep_cnt, par, gp;
  logic [KEY_BITS-1:0] in_key, rd_key;
  logic [SW-1:0]       rd_id;
  logic [4:0]          new_msb, rep_msb;

  logic          we, re;
  logic [SW-1:0] wslot, rslot;
  logic [EW-1:0] wdata, rd_data;

  mmh_ram #(.DEPTH(CAPACITY), .DW(EW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (AW'(wslot - SW'(1))),
    .wdata (wdata),
    .re    (re),
    .raddr (AW'(rslot - SW'(1))),
    .rdata (rd_data)
  );

  assign s_axis_tready = (state == ST_IDLE);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign in_first = s_axis_tuser[0];
  assign in_key   = KEY_BITS'(s_axis_tdata);
  assign base_cnt = in_first ? '0 : cnt;
  assign base_id  = in_first ? SW'(1) : nid;
  assign full     = (base_cnt >= SW'(CAPACITY));
  assign new_cnt  = base_cnt + SW'(1);
  assign rep_cnt  = full ? base_cnt : new_cnt;
  assign new_msb  = msb_index(32'(new_cnt));
  assign rep_msb  = msb_index(32'(rep_cnt));

  assign rd_key = rd_data[KEY_BITS-1:0];
  assign rd_id  = rd_data[EW-1:KEY_BITS];
  assign par    = pos >> 1;
  assign gp     = pos >> 2;
  assign swap   = lvl_min ? (item_key > rd_key) : (item_key < rd_key);
  assign move   = want_min ? (item_key < rd_key) : (item_key > rd_key);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    we         = 1'b0;
    wslot      = pos;
    wdata      = {item_id, item_key};
    re         = 1'b0;
    rslot      = pos;
    pos_next   = pos;
    want_next  = want_min;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          pos_next = new_cnt;
          if (full) begin
            state_next = ST_RROOT;
          end else if (new_cnt == SW'(1)) begin
            we         = 1'b1;
            wslot      = new_cnt;
            wdata      = {base_id, in_key};
            state_next = ST_RROOT;
          end else begin
            re         = 1'b1;
            rslot      = new_cnt >> 1;
            state_next = ST_PCMP;
          end
        end
      end
      ST_PCMP: begin
        if (swap) begin
          we        = 1'b1;
          wdata     = rd_data;
          pos_next  = par;
          want_next = !lvl_min;
        end else begin
          want_next = lvl_min;
        end
        if ((pos_next >> 2) != '0) begin
          re         = 1'b1;
          rslot      = pos_next >> 2;
          state_next = ST_GCMP;
        end else begin
          state_next = ST_WITEM;
        end
      end
      ST_GCMP: begin
        we = 1'b1;
        if (move) begin
          wdata    = rd_data;
          pos_next = gp;
          if ((gp >> 2) != '0) begin
            re    = 1'b1;
            rslot = gp >> 2;
          end else begin
            state_next = ST_WITEM;
          end
        end else begin
          state_next = ST_RROOT;
        end
      end
      ST_WITEM: begin
        we         = 1'b1;
        state_next = ST_RROOT;
      end
      ST_RROOT: begin
        re         = 1'b1;
        rslot      = SW'(1);
        state_next = ST_RLAST;
      end
      ST_RLAST: begin
        re         = 1'b1;
        rslot      = cnt;
        state_next = ST_RBOT;
      end
      ST_RBOT: begin
        re         = 1'b1;
        rslot      = bot;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      nid <= SW'(1);
    end else if (accept) begin
      cnt <= rep_cnt;
      nid <= full ? base_id : base_id + SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    pos      <= pos_next;
    want_min <= want_next;
    if (accept) begin
      item_key <= in_key;
      item_id  <= base_id;
      drop     <= full;
      lvl_min  <= !new_msb[0];
      bot      <= SW'(1) << rep_msb;
    end
    if (state == ST_RLAST) begin
      root_key <= rd_key;
      root_id  <= rd_id;
    end
    if (state == ST_RBOT) begin
      last_key <= rd_key;
      last_id  <= rd_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_DONE && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tuser <= drop;
      m_axis_tdata <= {{OUT_PAD_W{1'b0}},
                       KEY_OUT_W'(rd_key), ID_OUT_W'(rd_id),
                       KEY_OUT_W'(last_key), ID_OUT_W'(last_id),
                       KEY_OUT_W'(root_key), ID_OUT_W'(root_id),
                       ID_OUT_W'(cnt)};
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= SW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && drop) |-> cnt == SW'(CAPACITY))
    else $error("drop reported with room left");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PCMP || state == ST_GCMP || state == ST_WITEM) |->
      (pos != '0 && pos <= cnt))
    else $error("bubble-up slot outside occupied range");

  a_no_write_report: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RROOT || state == ST_RLAST || state == ST_RBOT || state == ST_DONE) |-> !we)
    else $error("store written during readout");

endmodule

// ===== test/tb_min_max_heap_insert.sv =====
// testbench for min_max_heap_insert: stream stimulus with random gaps and stalls,
// checked beat by beat against a min-max heap predictor kept in a scoreboard class
// depends on mmh_pkg and min_max_heap_insert from rtl
`timescale 1ns / 100ps

module tb_min_max_heap_insert;
  import mmh_pkg::*;

  localparam int CAP         = CAPACITY_DEF;
  localparam int TOTAL_ITEMS = 1550;
  localparam int LONG_HOLD   = 300;

  typedef struct packed {
    logic [OUT_PAD_W-1:0] pad;
    logic [KEY_OUT_W-1:0] bot_key;
    logic [ID_OUT_W-1:0]  bot_id;
    logic [KEY_OUT_W-1:0] last_key;
    logic [ID_OUT_W-1:0]  last_id;
    logic [KEY_OUT_W-1:0] root_key;
    logic [ID_OUT_W-1:0]  root_id;
    logic [ID_OUT_W-1:0]  count;
  } report_fields_t;

  typedef struct {
    logic           dropped;
    report_fields_t f;
  } heap_report_t;

  class heap_scoreboard;
    bit [KEY_OUT_W-1:0] slot_key [CAP+1];
    bit [ID_OUT_W-1:0]  slot_id  [CAP+1];
    int unsigned        held;
    int unsigned        id_next;
    heap_report_t       pending_reports[$];
    int                 mismatches;
    int                 reports_seen;

    function new();
      held         = 0;
      id_next      = 1;
      mismatches   = 0;
      reports_seen = 0;
    endfunction

    function int pending();
      return pending_reports.size();
    endfunction

    function int depth_of(int unsigned n);
      int d;
      d = 0;
      while (n > 1) begin
        n = n >> 1;
        d++;
      end
      return d;
    endfunction

    function void swap_slots(int a, int b);
      bit [KEY_OUT_W-1:0] k;
      bit [ID_OUT_W-1:0]  d;
      k = slot_key[a];
      d = slot_id[a];
      slot_key[a] = slot_key[b];
      slot_id[a]  = slot_id[b];
      slot_key[b] = k;
      slot_id[b]  = d;
    endfunction

    // grandparent climb on min levels or max levels
    function void climb(int slot, bit want_min);
      int g;
      bit move;
      while (slot >= 4) begin
        g = slot >> 2;
        move = want_min ? (slot_key[slot] < slot_key[g]) : (slot_key[slot] > slot_key[g]);
        if (!move) break;
        swap_slots(slot, g);
        slot = g;
      end
    endfunction

    function void sift_up(int slot);
      int p;
      if (slot <= 1) return;
      p = slot >> 1;
      if ((depth_of(slot) % 2) == 0) begin
        if (slot_key[slot] > slot_key[p]) begin
          swap_slots(slot, p);
          climb(p, 1'b0);
        end else begin
          climb(slot, 1'b1);
        end
      end else begin
        if (slot_key[slot] < slot_key[p]) begin
          swap_slots(slot, p);
          climb(p, 1'b1);
        end else begin
          climb(slot, 1'b0);
        end
      end
    endfunction

    function void note_insert(bit first, bit [IN_KEY_W-1:0] key);
      heap_report_t r;
      int bot;
      if (first) begin
        held    = 0;
        id_next = 1;
      end
      r.dropped = 1'b0;
      if (held >= CAP) begin
        r.dropped = 1'b1;
      end else begin
        held++;
        slot_key[held] = key;
        slot_id[held]  = id_next[ID_OUT_W-1:0];
        id_next++;
        sift_up(held);
      end
      r.f = '0;
      r.f.count = held[ID_OUT_W-1:0];
      if (held != 0) begin
        bot = 1 << depth_of(held);
        r.f.root_id  = slot_id[1];
        r.f.root_key = slot_key[1];
        r.f.last_id  = slot_id[held];
        r.f.last_key = slot_key[held];
        r.f.bot_id   = slot_id[bot];
        r.f.bot_key  = slot_key[bot];
      end
      pending_reports = {pending_reports, r};
    endfunction

    function bit field_ok(string name, logic [31:0] want, logic [31:0] got);
      if (got === want) return 1'b1;
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch at report %0d, %s: expected %0d, got %0d",
                 reports_seen, name, want, got);
      return 1'b0;
    endfunction

    function void check_report(logic [OUT_DATA_W-1:0] data, logic dropped);
      heap_report_t   want;
      report_fields_t got;
      bit             ok;
      got = data;
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output beat: count %0d root_key %0d", got.count, got.root_key);
        return;
      end
      want = pending_reports.pop_front();
      ok = field_ok("dropped", 32'(want.dropped), 32'(dropped));
      ok = field_ok("count", 32'(want.f.count), 32'(got.count)) && ok;
      ok = field_ok("root_id", 32'(want.f.root_id), 32'(got.root_id)) && ok;
      ok = field_ok("root_key", 32'(want.f.root_key), 32'(got.root_key)) && ok;
      ok = field_ok("last_id", 32'(want.f.last_id), 32'(got.last_id)) && ok;
      ok = field_ok("last_key", 32'(want.f.last_key), 32'(got.last_key)) && ok;
      ok = field_ok("bottom_first_id", 32'(want.f.bot_id), 32'(got.bot_id)) && ok;
      ok = field_ok("bottom_first_key", 32'(want.f.bot_key), 32'(got.bot_key)) && ok;
      ok = field_ok("pad", 32'(want.f.pad), 32'(got.pad)) && ok;
      reports_seen++;
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_KEY_W-1:0]   s_axis_tdata;    // key
  logic [0:0]            s_axis_tuser;    // first
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;    // count, root_id, root_key, last_id, last_key,
                                          // bottom_first_id, bottom_first_key, zero pad
  logic [0:0]            m_axis_tuser;    // dropped

  heap_scoreboard sb = new();
  bit             steady;
  bit             long_hold;
  int             inserts_sent;

  min_max_heap_insert dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #20_000_000;
    $display("tb_min_max_heap_insert failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [IN_KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return IN_KEY_W'($urandom_range(0, 65535));
    if (r < 60) return IN_KEY_W'($urandom_range(0, 15));
    if (r < 70) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    if (r < 85) return IN_KEY_W'($urandom_range(65520, 65535));
    return IN_KEY_W'($urandom_range(0, 255));
  endfunction

  task automatic send_item(input bit first, input logic [IN_KEY_W-1:0] key);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= key;
    s_axis_tuser  <= first;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    sb.note_insert(first, key);
    inserts_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic send_run(input int len, input bit restart, input bit noise);
    bit first;
    for (int i = 0; i < len; i++) begin
      first = (i == 0) ? restart : (noise && $urandom_range(0, 49) == 0);
      send_item(first, pick_key());
    end
  endtask

  task automatic check_out();
    if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
      sb.check_report(m_axis_tdata, m_axis_tuser[0]);
  endtask

  // output side: random stalls, plus one long hold-off on request
  initial begin : sink
    int stall;
    m_axis_tready <= 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) begin
          @(posedge clk);
          check_out();
        end
      end
      stall = pick_gap();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) begin
          @(posedge clk);
          check_out();
        end
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      check_out();
    end
  end

  initial begin : stim
    int len;
    steady        = 1'b0;
    long_hold     = 1'b0;
    inserts_sent  = 0;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extremes, equal keys, first on a held heap and right after another first
    send_item(1'b0, 16'd100);
    send_item(1'b0, 16'hFFFF);
    send_item(1'b0, 16'h0000);
    send_item(1'b0, 16'd50);
    send_item(1'b0, 16'd200);
    send_item(1'b0, 16'h8000);
    send_item(1'b0, 16'd100);
    send_item(1'b0, 16'd100);
    send_item(1'b0, 16'hFFFF);
    send_item(1'b0, 16'h0000);
    send_item(1'b0, 16'd1);
    send_item(1'b1, 16'hFFFF);
    send_item(1'b1, 16'h0000);
    send_item(1'b0, 16'h0000);
    send_item(1'b0, 16'h0000);
    // falling keys force climbs through the grandparents
    send_item(1'b1, 16'd1000);
    for (int k = 900; k >= 100; k -= 100) send_item(1'b0, k[IN_KEY_W-1:0]);
    wait_drained();

    // block fills up while the output holds off
    long_hold = 1'b1;
    steady    = 1'b1;
    send_run(40, 1'b1, 1'b0);
    steady    = 1'b0;
    wait_drained();

    // fill the heap to capacity, then overflow it
    steady = 1'b1;
    send_run(300, 1'b1, 1'b0);
    steady = 1'b0;
    send_run(724, 1'b0, 1'b0);
    send_run(12, 1'b0, 1'b0);
    wait_drained();

    while (inserts_sent < TOTAL_ITEMS) begin
      len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 40) : $urandom_range(60, 200);
      if (len > TOTAL_ITEMS - inserts_sent) len = TOTAL_ITEMS - inserts_sent;
      steady = ($urandom_range(0, 4) == 0);
      send_run(len, $urandom_range(0, 9) != 0, 1'b1);
      steady = 1'b0;
      if ($urandom_range(0, 6) == 0) wait_drained();
    end

    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_min_max_heap_insert passed");
    end else begin
      $display("tb_min_max_heap_insert failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/mmh_pkg.sv
rtl/mmh_ram.sv
rtl/min_max_heap_insert.sv
test/tb_min_max_heap_insert.sv
